>>> rtl/core/oaep_pkg.sv
// ----------------------------------------------------------------------------
// oaep_pkg
// Shared sizes, codes and constant tables for the OAEP SHA-1/MGF1 decoder.
// ----------------------------------------------------------------------------
package oaep_pkg;

   localparam int MAX_BLOCK_BYTES = 256;
   localparam int OUT_BYTES       = 8;
   localparam int HASH_BYTES      = 20;
   localparam int LABEL_BYTES     = 10;
   localparam int CTR_BYTES       = 4;
   localparam int CFG_W           = 9;
   localparam int ADDR_W          = $clog2(MAX_BLOCK_BYTES);
   localparam int CNT_W           = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int POS_W           = CNT_W + 1;
   localparam int MCNT_W          = $clog2(MAX_BLOCK_BYTES / HASH_BYTES + 2);
   localparam int OCNT_W          = $clog2(OUT_BYTES + 1);
   localparam int TAKE_W          = $clog2(HASH_BYTES + 1);
   localparam int HASH_W          = 8 * HASH_BYTES;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_LABEL = 2'd2,
      STATUS_PAD   = 2'd3
   } status_type;

   // control from the sequencer to the hash core
   typedef struct packed {
      logic init;
      logic push;
   } sha_ctl_type;

   localparam logic [HASH_W-1:0] SHA1_IV = {
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // label text "SHA-1 MGF1"
   function automatic logic [7:0] label_byte(input logic [3:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0:    b = 8'h53;
         4'd1:    b = 8'h48;
         4'd2:    b = 8'h41;
         4'd3:    b = 8'h2D;
         4'd4:    b = 8'h31;
         4'd5:    b = 8'h20;
         4'd6:    b = 8'h4D;
         4'd7:    b = 8'h47;
         4'd8:    b = 8'h46;
         4'd9:    b = 8'h31;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // sha-1 round constant by round number
   function automatic logic [31:0] round_const(input logic [6:0] t);
      logic [31:0] k;
      if (t < 7'd20) begin
         k = 32'h5A827999;
      end else if (t < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (t < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

endpackage

>>> rtl/core/oaep_sha1_mgf1_decode_unit.sv
// loading: L bytes load at one byte a cycle while the unit is idle; a new
//   block waits until the last result beat of the old one is registered;
//   after the last byte the sha-1 core runs its compressions (17 of them for
//   L = 256), each an 80-round loop, then the unit unmasks, checks and packs;
//   a short-block error beat is registered once the result slot is free
// reset: synchronous, active high; block length 256, byte/round counters clear
// ----------------------------------------------------------------------------
// oaep_sha1_mgf1_decode_unit
// OAEP decoder: stores an encoded block, unmasks seed and data block with
// MGF1-SHA1, checks the label hash and padding, then emits the message.
// ----------------------------------------------------------------------------
module oaep_sha1_mgf1_decode_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [63:0]                   rsp_message_word,
   output logic [3:0]                    rsp_byte_count,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [oaep_pkg::CFG_W-1:0]    csr_block_length
);

   localparam int ADDR_W = oaep_pkg::ADDR_W;
   localparam int CNT_W  = oaep_pkg::CNT_W;
   localparam int POS_W  = oaep_pkg::POS_W;
   localparam int WORD_W = 8 * oaep_pkg::OUT_BYTES;
   localparam int HW     = oaep_pkg::HASH_W;

   typedef enum logic [3:0] {
      T_IDLE, T_FEED, T_WAIT, T_APPLY, T_CHECK, T_SCAN, T_GATHER, T_EMIT, T_ERR
   } state_type;

   typedef enum logic [1:0] {J_LABEL, J_SEED, J_DB} job_type;

   state_type                          state_ff, state_in;
   job_type                            job_ff, job_in;
   logic [oaep_pkg::CFG_W-1:0]         blen_ff, blen_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in, cnt_next;
   logic [POS_W-1:0]                   pos_ff, pos_in;
   logic [5:0]                         blk_ff, blk_in;
   logic [oaep_pkg::MCNT_W-1:0]        mcnt_ff, mcnt_in;
   logic                               push_ff, push_in;
   logic                               fsel_ff, fsel_in;
   logic [7:0]                         fconst_ff, fconst_in;
   logic [HW-1:0]                      label_ff, label_in;
   logic [HW-1:0]                      dig_ff, dig_in;
   logic [CNT_W-1:0]                   ptr_ff, ptr_in;
   logic [CNT_W-1:0]                   rem_ff, rem_in;
   logic [oaep_pkg::TAKE_W-1:0]        take_ff, take_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]                   rd_q_ff, rd_q_in;
   logic                               wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]                  wr_addr_ff, wr_addr_in;
   logic [7:0]                         wr_key_ff, wr_key_in;
   logic                               mism_ff, mism_in;
   logic [WORD_W-1:0]                  word_ff, word_in;
   logic [oaep_pkg::OCNT_W-1:0]        wlen_ff, wlen_in;
   logic [oaep_pkg::OCNT_W-1:0]        icnt_ff, icnt_in;
   logic [oaep_pkg::OCNT_W-1:0]        bcnt_ff, bcnt_in;
   oaep_pkg::status_type               err_ff, err_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [63:0]                        rsp_word_ff, rsp_word_in;
   logic [3:0]                         rsp_count_ff, rsp_count_in;
   oaep_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [7:0]                         store_mem [oaep_pkg::MAX_BLOCK_BYTES];
   logic [7:0]                         rd_data_ff;
   logic                               mem_we;
   logic [ADDR_W-1:0]                  mem_wa, mem_ra;
   logic [7:0]                         mem_wd;

   logic [CNT_W-1:0]                   len;
   logic [POS_W-1:0]                   mlen, src, total, feed_addr;
   logic [15:0]                        mbits;
   logic                               feed_mem;
   logic [7:0]                         feed_byte;
   logic                               accept, slot_free, g_start;
   logic [CNT_W-1:0]                   rest;
   oaep_pkg::sha_ctl_type              sha_ctl;
   logic                               sha_done;
   logic [HW-1:0]                      sha_chain;

   // effective block length
   always_comb begin
      if (int'(blen_ff) > oaep_pkg::MAX_BLOCK_BYTES) begin
         len = CNT_W'(oaep_pkg::MAX_BLOCK_BYTES);
      end else begin
         len = CNT_W'(blen_ff);
      end
   end

   // hash message geometry for the current job
   always_comb begin
      unique case (job_ff)
         J_LABEL: begin
            mlen = POS_W'(oaep_pkg::LABEL_BYTES);
            src  = '0;
         end
         J_SEED: begin
            mlen = POS_W'(len) - POS_W'(oaep_pkg::HASH_BYTES - oaep_pkg::CTR_BYTES);
            src  = POS_W'(oaep_pkg::HASH_BYTES);
         end
         default: begin
            mlen = POS_W'(oaep_pkg::HASH_BYTES + oaep_pkg::CTR_BYTES);
            src  = '0;
         end
      endcase
      mbits     = 16'({mlen, 3'b000});
      total     = ((POS_W'(mlen + POS_W'(8)) >> 6) + POS_W'(1)) << 6;
      feed_addr = src + pos_ff - POS_W'(oaep_pkg::CTR_BYTES);
   end

   // next byte of the padded hash message
   always_comb begin
      feed_mem  = 1'b0;
      feed_byte = 8'h00;
      if (pos_ff < mlen) begin
         if (job_ff == J_LABEL) begin
            feed_byte = oaep_pkg::label_byte(pos_ff[3:0]);
         end else if (pos_ff < POS_W'(oaep_pkg::CTR_BYTES)) begin
            if (pos_ff == POS_W'(oaep_pkg::CTR_BYTES - 1)) begin
               feed_byte = 8'(mcnt_ff);
            end
         end else begin
            feed_mem = 1'b1;
         end
      end else if (pos_ff == mlen) begin
         feed_byte = 8'h80;
      end else if (pos_ff == total - POS_W'(1)) begin
         feed_byte = mbits[7:0];
      end else if (pos_ff == total - POS_W'(2)) begin
         feed_byte = mbits[15:8];
      end
   end

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_next  = cnt_ff + CNT_W'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      blen_in       = blen_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      blk_in        = blk_ff;
      mcnt_in       = mcnt_ff;
      push_in       = 1'b0;
      fsel_in       = fsel_ff;
      fconst_in     = fconst_ff;
      label_in      = label_ff;
      dig_in        = dig_ff;
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      take_in       = take_ff;
      rd_pend_in    = 1'b0;
      rd_q_in       = rd_q_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_key_in     = wr_key_ff;
      mism_in       = mism_ff;
      word_in       = word_ff;
      wlen_in       = wlen_ff;
      icnt_in       = icnt_ff;
      bcnt_in       = bcnt_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      g_start       = 1'b0;
      rest          = '0;
      mem_we        = wr_pend_ff;
      mem_wa        = wr_addr_ff;
      mem_wd        = rd_data_ff ^ wr_key_ff;
      mem_ra        = ptr_ff[ADDR_W-1:0];

      // configuration write
      if (csr_valid) begin
         blen_in = csr_block_length;
      end

      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               if (int'(cnt_ff) < oaep_pkg::MAX_BLOCK_BYTES) begin
                  mem_we = 1'b1;
                  mem_wa = cnt_ff[ADDR_W-1:0];
                  mem_wd = req_data_byte;
               end
               if (cnt_next < len) begin
                  cnt_in = cnt_next;
               end else begin
                  cnt_in = '0;
                  if (len < CNT_W'(2 * oaep_pkg::HASH_BYTES + 1)) begin
                     err_in   = oaep_pkg::STATUS_SHORT;
                     state_in = T_ERR;
                  end else begin
                     job_in   = J_LABEL;
                     pos_in   = '0;
                     blk_in   = '0;
                     mcnt_in  = '0;
                     ptr_in   = '0;
                     rem_in   = CNT_W'(oaep_pkg::HASH_BYTES);
                     state_in = T_FEED;
                  end
               end
            end
         end
         T_FEED: begin
            // one message byte per cycle toward the hash core
            mem_ra    = feed_addr[ADDR_W-1:0];
            push_in   = 1'b1;
            fsel_in   = feed_mem;
            fconst_in = feed_byte;
            pos_in    = pos_ff + POS_W'(1);
            blk_in    = blk_ff + 6'd1;
            if (&blk_ff) begin
               state_in = T_WAIT;
            end
         end
         T_WAIT: begin
            if (sha_done) begin
               if (pos_ff != total) begin
                  state_in = T_FEED;
               end else if (job_ff == J_LABEL) begin
                  label_in = sha_chain;
                  job_in   = J_SEED;
                  pos_in   = '0;
                  mcnt_in  = '0;
                  state_in = T_FEED;
               end else begin
                  dig_in = sha_chain;
                  if (rem_ff > CNT_W'(oaep_pkg::HASH_BYTES)) begin
                     take_in = oaep_pkg::TAKE_W'(oaep_pkg::HASH_BYTES);
                  end else begin
                     take_in = oaep_pkg::TAKE_W'(rem_ff);
                  end
                  state_in = T_APPLY;
               end
            end
         end
         T_APPLY: begin
            // read, xor with mask byte, write back in the following cycle
            if (take_ff != '0) begin
               wr_pend_in = 1'b1;
               wr_addr_in = ptr_ff[ADDR_W-1:0];
               wr_key_in  = dig_ff[HW-1 -: 8];
               dig_in     = dig_ff << 8;
               ptr_in     = ptr_ff + CNT_W'(1);
               take_in    = take_ff - oaep_pkg::TAKE_W'(1);
               rem_in     = rem_ff - CNT_W'(1);
            end else if (!wr_pend_ff) begin
               pos_in = '0;
               if (rem_ff != '0) begin
                  mcnt_in  = mcnt_ff + oaep_pkg::MCNT_W'(1);
                  state_in = T_FEED;
               end else if (job_ff == J_SEED) begin
                  job_in   = J_DB;
                  mcnt_in  = '0;
                  rem_in   = len - CNT_W'(oaep_pkg::HASH_BYTES);
                  ptr_in   = CNT_W'(oaep_pkg::HASH_BYTES);
                  state_in = T_FEED;
               end else begin
                  ptr_in   = CNT_W'(oaep_pkg::HASH_BYTES);
                  mism_in  = 1'b0;
                  state_in = T_CHECK;
               end
            end
         end
         T_CHECK: begin
            // compare unmasked label hash
            if (rd_pend_ff) begin
               if (rd_data_ff != label_ff[HW-1 -: 8]) begin
                  mism_in = 1'b1;
               end
               label_in = label_ff << 8;
            end
            if (ptr_ff < CNT_W'(2 * oaep_pkg::HASH_BYTES)) begin
               rd_pend_in = 1'b1;
               ptr_in     = ptr_ff + CNT_W'(1);
            end else if (!rd_pend_ff) begin
               if (mism_ff) begin
                  err_in   = oaep_pkg::STATUS_LABEL;
                  state_in = T_ERR;
               end else begin
                  state_in = T_SCAN;
               end
            end
         end
         T_SCAN: begin
            // zero padding up to the separator
            if (rd_pend_ff && rd_data_ff == 8'h01) begin
               if (rd_q_ff + CNT_W'(1) >= len) begin
                  err_in   = oaep_pkg::STATUS_PAD;
                  state_in = T_ERR;
               end else begin
                  ptr_in   = rd_q_ff + CNT_W'(1);
                  g_start  = 1'b1;
                  state_in = T_GATHER;
               end
            end else if (rd_pend_ff && rd_data_ff != 8'h00) begin
               err_in   = oaep_pkg::STATUS_PAD;
               state_in = T_ERR;
            end else if (ptr_ff < len) begin
               rd_pend_in = 1'b1;
               rd_q_in    = ptr_ff;
               ptr_in     = ptr_ff + CNT_W'(1);
            end else if (!rd_pend_ff) begin
               err_in   = oaep_pkg::STATUS_PAD;
               state_in = T_ERR;
            end
         end
         T_GATHER: begin
            // pack message bytes, first byte lowest
            if (rd_pend_ff) begin
               for (int k = 0; k < oaep_pkg::OUT_BYTES; k++) begin
                  if (bcnt_ff == oaep_pkg::OCNT_W'(k)) begin
                     word_in[8*k +: 8] = rd_data_ff;
                  end
               end
               bcnt_in = bcnt_ff + oaep_pkg::OCNT_W'(1);
            end
            if (icnt_ff < wlen_ff) begin
               rd_pend_in = 1'b1;
               ptr_in     = ptr_ff + CNT_W'(1);
               icnt_in    = icnt_ff + oaep_pkg::OCNT_W'(1);
            end else if (!rd_pend_ff && bcnt_ff == wlen_ff) begin
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = 64'(word_ff);
               rsp_count_in  = 4'(wlen_ff);
               rsp_status_in = oaep_pkg::STATUS_OK;
               rsp_last_in   = (ptr_ff == len);
               if (ptr_ff == len) begin
                  state_in = T_IDLE;
               end else begin
                  g_start  = 1'b1;
                  state_in = T_GATHER;
               end
            end
         end
         T_ERR: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = '0;
               rsp_count_in  = '0;
               rsp_status_in = err_ff;
               rsp_last_in   = 1'b1;
               state_in      = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase

      // set up the next output word
      if (g_start) begin
         rest    = len - ptr_in;
         word_in = '0;
         icnt_in = '0;
         bcnt_in = '0;
         if (rest > CNT_W'(oaep_pkg::OUT_BYTES)) begin
            wlen_in = oaep_pkg::OCNT_W'(oaep_pkg::OUT_BYTES);
         end else begin
            wlen_in = oaep_pkg::OCNT_W'(rest);
         end
      end
   end

   // block store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= store_mem[mem_ra];
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         job_ff       <= J_LABEL;
         blen_ff      <= oaep_pkg::CFG_W'(256);
         cnt_ff       <= '0;
         push_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         blen_ff      <= blen_in;
         cnt_ff       <= cnt_in;
         push_ff      <= push_in;
         rd_pend_ff   <= rd_pend_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      blk_ff        <= blk_in;
      mcnt_ff       <= mcnt_in;
      fsel_ff       <= fsel_in;
      fconst_ff     <= fconst_in;
      label_ff      <= label_in;
      dig_ff        <= dig_in;
      ptr_ff        <= ptr_in;
      rem_ff        <= rem_in;
      take_ff       <= take_in;
      rd_q_ff       <= rd_q_in;
      wr_addr_ff    <= wr_addr_in;
      wr_key_ff     <= wr_key_in;
      mism_ff       <= mism_in;
      word_ff       <= word_in;
      wlen_ff       <= wlen_in;
      icnt_ff       <= icnt_in;
      bcnt_ff       <= bcnt_in;
      err_ff        <= err_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // shared sha-1 engine
   assign sha_ctl.init = (state_ff == T_FEED) && (pos_ff == '0);
   assign sha_ctl.push = push_ff;

   oaep_sha1_core u_sha1 (
      .clock     (clock),
      .reset     (reset),
      .ctl       (sha_ctl),
      .byte_data (fsel_ff ? rd_data_ff : fconst_ff),
      .done      (sha_done),
      .chain     (sha_chain)
   );

   assign req_stall        = (state_ff != T_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_message_word = rsp_word_ff;
   assign rsp_byte_count   = rsp_count_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> rtl/core/oaep_sha1_core.sv
// ----------------------------------------------------------------------------
// oaep_sha1_core
// Iterative SHA-1 compression: takes 64 bytes, then one round per cycle.
// ----------------------------------------------------------------------------
module oaep_sha1_core (
   input  logic                            clock,
   input  logic                            reset,
   input  oaep_pkg::sha_ctl_type           ctl,
   input  logic [7:0]                      byte_data,
   output logic                            done,
   output logic [oaep_pkg::HASH_W-1:0]     chain
);

   typedef enum logic [1:0] {S_LOAD, S_ROUND, S_FINAL} state_type;

   state_type                       state_ff, state_in;
   logic [5:0]                      load_cnt_ff, load_cnt_in;
   logic [6:0]                      round_ff, round_in;
   logic [511:0]                    sched_ff, sched_in;
   logic [31:0]                     a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]                     a_in, b_in, c_in, d_in, e_in;
   logic [oaep_pkg::HASH_W-1:0]     chain_ff, chain_in;
   logic                            done_ff, done_in;
   logic [31:0]                     w0, w2, w8, w13, w_mix, w_new, f_val, t_sum;

   // schedule taps and round function
   always_comb begin
      w0    = sched_ff[511 -: 32];
      w2    = sched_ff[447 -: 32];
      w8    = sched_ff[255 -: 32];
      w13   = sched_ff[95 -: 32];
      w_mix = w13 ^ w8 ^ w2 ^ w0;
      w_new = {w_mix[30:0], w_mix[31]};
      if (round_ff < 7'd20) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
      end else if (round_ff < 7'd40) begin
         f_val = b_ff ^ c_ff ^ d_ff;
      end else if (round_ff < 7'd60) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
      end
      t_sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff
            + oaep_pkg::round_const(round_ff) + w0;
   end

   // sequencing of load, rounds and chain update
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      round_in    = round_ff;
      sched_in    = sched_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      c_in        = c_ff;
      d_in        = d_ff;
      e_in        = e_ff;
      chain_in    = chain_ff;
      done_in     = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (ctl.init) begin
               chain_in = oaep_pkg::SHA1_IV;
            end
            if (ctl.push) begin
               sched_in    = {sched_ff[503:0], byte_data};
               load_cnt_in = load_cnt_ff + 6'd1;
               if (&load_cnt_ff) begin
                  state_in = S_ROUND;
                  round_in = '0;
                  a_in     = chain_ff[159:128];
                  b_in     = chain_ff[127:96];
                  c_in     = chain_ff[95:64];
                  d_in     = chain_ff[63:32];
                  e_in     = chain_ff[31:0];
               end
            end
         end
         S_ROUND: begin
            sched_in = {sched_ff[479:0], w_new};
            e_in     = d_ff;
            d_in     = c_ff;
            c_in     = {b_ff[1:0], b_ff[31:2]};
            b_in     = a_ff;
            a_in     = t_sum;
            round_in = round_ff + 7'd1;
            if (round_ff == 7'd79) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            chain_in = {chain_ff[159:128] + a_ff, chain_ff[127:96] + b_ff,
                        chain_ff[95:64] + c_ff, chain_ff[63:32] + d_ff,
                        chain_ff[31:0] + e_ff};
            done_in  = 1'b1;
            state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         load_cnt_ff <= '0;
         round_ff    <= '0;
         done_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         round_ff    <= round_in;
         done_ff     <= done_in;
      end
      sched_ff <= sched_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      chain_ff <= chain_in;
   end

   assign done  = done_ff;
   assign chain = chain_ff;

endmodule

>>> rtl/core/oaep_decode_checker.sv
// ----------------------------------------------------------------------------
// oaep_decode_checker
// Port-level checks on the result channel of the OAEP decoder.
// ----------------------------------------------------------------------------
module oaep_decode_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [7:0]                    req_data_byte,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [63:0]                   rsp_message_word,
   input logic [3:0]                    rsp_byte_count,
   input logic [1:0]                    rsp_status,
   input logic                          rsp_last,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [oaep_pkg::CFG_W-1:0]    csr_block_length
);

   // stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_message_word)
                                 && $stable(rsp_last) && $stable(rsp_byte_count))
      else $error("result beat changed under stall");

   // error beats are empty and final
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != oaep_pkg::STATUS_OK |->
         rsp_byte_count == 4'd0 && rsp_message_word == 64'd0 && rsp_last)
      else $error("malformed error beat");

   // message beats carry at least one byte
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == oaep_pkg::STATUS_OK |->
         rsp_byte_count != 4'd0 && rsp_byte_count <= 4'(oaep_pkg::OUT_BYTES))
      else $error("bad byte count");

   // only the final message beat may be partial
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == oaep_pkg::STATUS_OK && !rsp_last |->
         rsp_byte_count == 4'(oaep_pkg::OUT_BYTES))
      else $error("partial beat before last");

   // no result right after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind oaep_sha1_mgf1_decode_unit oaep_decode_checker u_checker (.*);

>>> sim/oaep_sha1_mgf1_decode_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oaep_sha1_mgf1_decode_unit_tb
// Feeds encoded blocks to the OAEP decoder. It runs a short table of short
// blocks, then builds random OAEP blocks with a built-in encoder, some of them
// damaged on purpose. Every response beat is checked against a software decoder.
// ----------------------------------------------------------------------------
module oaep_sha1_mgf1_decode_unit_tb;

   typedef logic [7:0] bytes_type[];

   typedef struct {
      logic [63:0]          word;
      logic [3:0]           count;
      oaep_pkg::status_type status;
      logic                 last;
   } beat_type;

   typedef struct {
      int         blen;    // block length to set first, -1 keeps it
      logic [7:0] data;
   } row_type;

   localparam int CYCLE_LIMIT = 600000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [7:0]                     req_data_byte;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [63:0]                    rsp_message_word;
   logic [3:0]                     rsp_byte_count;
   logic [1:0]                     rsp_status;
   logic                           rsp_last;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [oaep_pkg::CFG_W-1:0]     csr_block_length;

   beat_type    pending_beats[$];
   beat_type    scratch_beats[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          idle_req = 0;
   int          idle_rsp = 0;

   // decoder copy
   logic [7:0]  store_copy[oaep_pkg::MAX_BLOCK_BYTES];
   int          fill_count = 0;
   int          length_reg = oaep_pkg::MAX_BLOCK_BYTES;

   oaep_sha1_mgf1_decode_unit DUT (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // sha-1 digest of a byte string
   function automatic logic [159:0] sha1_of(input bytes_type msg);
      bytes_type   buffer;
      int          n, total, blk, t;
      logic [63:0] bits;
      logic [31:0] h[5];
      logic [31:0] w[80];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      n = msg.size();
      total = ((n + 8) / 64 + 1) * 64;
      bits = 64'(n) * 8;
      buffer = new[total];
      for (int i = 0; i < total; i++) begin
         buffer[i] = (i < n) ? msg[i] : ((i == n) ? 8'h80 : 8'h00);
      end
      for (int i = 0; i < 8; i++) begin
         buffer[total - 1 - i] = bits[8*i +: 8];
      end
      h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
      h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
      for (blk = 0; blk < total; blk += 64) begin
         for (t = 0; t < 16; t++) begin
            w[t] = {buffer[blk+4*t], buffer[blk+4*t+1], buffer[blk+4*t+2], buffer[blk+4*t+3]};
         end
         for (t = 16; t < 80; t++) begin
            w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
         end
         a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
         for (t = 0; t < 80; t++) begin
            if (t < 20) begin
               f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (t < 40) begin
               f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (t < 60) begin
               f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
               f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            tmp = rol(a, 5) + f + e + k + w[t];
            e = d; d = c; c = rol(b, 30); b = a; a = tmp;
         end
         h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
      end
      return {h[0], h[1], h[2], h[3], h[4]};
   endfunction

   // mgf1 mask of dlen bytes over a seed
   function automatic bytes_type mgf1_mask(input bytes_type seed, input int dlen);
      bytes_type     mask, chunk;
      logic [159:0]  dig;
      int            done;
      logic [31:0]   ctr;
      mask = new[dlen];
      chunk = new[seed.size() + 4];
      for (int i = 0; i < seed.size(); i++) chunk[i + 4] = seed[i];
      done = 0;
      ctr = 0;
      while (done < dlen) begin
         {chunk[0], chunk[1], chunk[2], chunk[3]} = ctr;
         dig = sha1_of(chunk);
         for (int j = 0; j < oaep_pkg::HASH_BYTES && done < dlen; j++) begin
            mask[done] = dig[159 - 8*j -: 8];
            done++;
         end
         ctr++;
      end
      return mask;
   endfunction

   function automatic logic [159:0] label_digest();
      bytes_type lbl;
      lbl = '{8'h53, 8'h48, 8'h41, 8'h2D, 8'h31, 8'h20, 8'h4D, 8'h47, 8'h46, 8'h31};
      return sha1_of(lbl);
   endfunction

   function automatic beat_type fail_beat(input oaep_pkg::status_type code);
      beat_type r;
      r.word = '0; r.count = '0; r.status = code; r.last = 1'b1;
      return r;
   endfunction

   // decoder copy: store one byte, decode when a block is complete
   function automatic void decode_byte(input logic [7:0] data, ref beat_type outq[$]);
      int            len, sep, pos, cnt;
      bytes_type     part, mask;
      logic [159:0]  lh;
      bit            found;
      beat_type      r;
      len = (length_reg > oaep_pkg::MAX_BLOCK_BYTES) ? oaep_pkg::MAX_BLOCK_BYTES : length_reg;
      if (fill_count < oaep_pkg::MAX_BLOCK_BYTES) store_copy[fill_count] = data;
      fill_count++;
      if (fill_count < len) return;
      fill_count = 0;
      if (len < 2 * oaep_pkg::HASH_BYTES + 1) begin
         outq.push_back(fail_beat(oaep_pkg::STATUS_SHORT));
         return;
      end
      // seed first, then data block
      part = new[len - oaep_pkg::HASH_BYTES];
      for (int i = 0; i < len - oaep_pkg::HASH_BYTES; i++) begin
         part[i] = store_copy[oaep_pkg::HASH_BYTES + i];
      end
      mask = mgf1_mask(part, oaep_pkg::HASH_BYTES);
      for (int i = 0; i < oaep_pkg::HASH_BYTES; i++) store_copy[i] ^= mask[i];
      part = new[oaep_pkg::HASH_BYTES];
      for (int i = 0; i < oaep_pkg::HASH_BYTES; i++) part[i] = store_copy[i];
      mask = mgf1_mask(part, len - oaep_pkg::HASH_BYTES);
      for (int i = 0; i < len - oaep_pkg::HASH_BYTES; i++) begin
         store_copy[oaep_pkg::HASH_BYTES + i] ^= mask[i];
      end
      lh = label_digest();
      for (int i = 0; i < oaep_pkg::HASH_BYTES; i++) begin
         if (store_copy[oaep_pkg::HASH_BYTES + i] != lh[159 - 8*i -: 8]) begin
            outq.push_back(fail_beat(oaep_pkg::STATUS_LABEL));
            return;
         end
      end
      found = 0;
      sep = 0;
      for (int i = 2 * oaep_pkg::HASH_BYTES; i < len; i++) begin
         if (store_copy[i] == 8'h01) begin
            found = 1; sep = i + 1; break;
         end
         if (store_copy[i] != 8'h00) begin
            outq.push_back(fail_beat(oaep_pkg::STATUS_PAD));
            return;
         end
      end
      if (!found || sep >= len) begin
         outq.push_back(fail_beat(oaep_pkg::STATUS_PAD));
         return;
      end
      for (pos = sep; pos < len; pos += oaep_pkg::OUT_BYTES) begin
         cnt = (len - pos > oaep_pkg::OUT_BYTES) ? oaep_pkg::OUT_BYTES : len - pos;
         r.word = '0;
         for (int i = 0; i < cnt; i++) r.word[8*i +: 8] = store_copy[pos + i];
         r.count = 4'(cnt);
         r.status = oaep_pkg::STATUS_OK;
         r.last = (pos + cnt >= len);
         outq.push_back(r);
      end
   endfunction

   // encoder: kind 0 good, 1 bad label, 2 nonzero pad, 3 no separator,
   // 4 empty message, 5 noise
   function automatic bytes_type encode_block(input int len, input int kind);
      bytes_type     blk, db, seed, mask;
      logic [159:0]  lh;
      int            dl, mlen, sep;
      blk = new[len];
      if (kind == 5 || len < 2 * oaep_pkg::HASH_BYTES + 1) begin
         for (int i = 0; i < len; i++) blk[i] = 8'($urandom);
         return blk;
      end
      dl = len - oaep_pkg::HASH_BYTES;
      db = new[dl];
      lh = label_digest();
      for (int i = 0; i < dl; i++) db[i] = 8'h00;
      for (int i = 0; i < oaep_pkg::HASH_BYTES; i++) db[i] = lh[159 - 8*i -: 8];
      mlen = (len - 42 >= 1) ? $urandom_range(len - 42, 1) : 0;
      if (kind == 4) mlen = 0;
      sep = dl - 1 - mlen;
      if (kind != 3) db[sep] = 8'h01;
      for (int i = sep + 1; i < dl; i++) db[i] = 8'($urandom);
      if (kind == 1) begin
         db[$urandom_range(oaep_pkg::HASH_BYTES - 1, 0)] ^= 8'(1 << $urandom_range(7, 0));
      end
      if (kind == 2) db[$urandom_range(sep, oaep_pkg::HASH_BYTES)] = 8'($urandom_range(255, 2));
      seed = new[oaep_pkg::HASH_BYTES];
      for (int i = 0; i < oaep_pkg::HASH_BYTES; i++) seed[i] = 8'($urandom);
      mask = mgf1_mask(seed, dl);
      for (int i = 0; i < dl; i++) db[i] ^= mask[i];
      mask = mgf1_mask(db, oaep_pkg::HASH_BYTES);
      for (int i = 0; i < oaep_pkg::HASH_BYTES; i++) blk[i] = seed[i] ^ mask[i];
      for (int i = 0; i < dl; i++) blk[oaep_pkg::HASH_BYTES + i] = db[i];
      return blk;
   endfunction

   // send one beat on the request channel and feed the decoder copy
   task automatic send_byte(input logic [7:0] data);
      while ($urandom_range(99, 0) < idle_req) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(data, pending_beats);
   endtask

   // write the block length once everything has drained
   task automatic write_length(input int value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_block_length <= oaep_pkg::CFG_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      length_reg = value;
   endtask

   // response checker and random stall
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat word %h count %0d status %0d last %0d", $time,
                     rsp_message_word, rsp_byte_count, rsp_status, rsp_last);
            error_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_message_word !== want.word) begin
               $display("%0t: word expected %h actual %h", $time, want.word, rsp_message_word);
               error_count++;
            end
            if (rsp_byte_count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count,
                        rsp_byte_count);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99, 0) < idle_rsp);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // short blocks with typed-in results
   row_type directed[] = '{
      '{0, 8'h00}, '{-1, 8'hFF}, '{-1, 8'h55}, '{-1, 8'hAA}, '{-1, 8'h01},
      '{1, 8'h80}, '{-1, 8'h7F}, '{2, 8'h0F}, '{-1, 8'hF0},
      '{3, 8'h12}, '{-1, 8'h34}, '{-1, 8'h56},
      '{40, 8'hC3}
   };

   // main sequence
   initial begin
      int        lens[] = '{42, 3, 41, 48, 0, 43, 5, 44, 0};
      int        nblk, kind, blen;
      bytes_type blk;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      csr_valid = 1'b0;
      csr_block_length = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_req = 24;
      idle_rsp = 49;
      foreach (directed[r]) begin
         if (directed[r].blen >= 0) write_length(directed[r].blen);
         if (directed[r].blen == 40) begin
            // forty bytes, one short of the minimum
            for (int i = 0; i < 39; i++) send_byte(8'($urandom));
         end
         send_byte(directed[r].data);
         scratch_beats.delete();
         if (pending_beats.size() != 0) begin
            scratch_beats.push_back(pending_beats.pop_back());
            pending_beats.push_back(fail_beat(oaep_pkg::STATUS_SHORT));
         end
      end

      // random blocks, some of them damaged
      foreach (lens[p]) begin
         if (p == 3) begin
            idle_req = 49; idle_rsp = 24;
         end else if (p == 6) begin
            idle_req = 0; idle_rsp = 0;
         end
         write_length(lens[p]);
         blen = (lens[p] > oaep_pkg::MAX_BLOCK_BYTES) ? oaep_pkg::MAX_BLOCK_BYTES : lens[p];
         nblk = (blen == 0) ? 4 : 1;
         for (int n = 0; n < nblk; n++) begin
            if (blen == 0) begin
               send_byte(8'($urandom));
            end else begin
               kind = $urandom_range(11, 0);
               kind = (kind < 6) ? 0 : kind - 5;
               if (kind > 5) kind = 0;
               blk = encode_block(blen, kind);
               foreach (blk[i]) send_byte(blk[i]);
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_beats.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/oaep_pkg.sv
rtl/core/oaep_sha1_core.sv
rtl/core/oaep_sha1_mgf1_decode_unit.sv
rtl/core/oaep_decode_checker.sv
sim/oaep_sha1_mgf1_decode_unit_tb.sv
